/* hw/rtl/apd_pkg.sv */
// Shared types, constants and codes of the accelerometer peak detector.
package apd_pkg;

    localparam int MAG_W      = 24;
    localparam int SQ_W       = 32;
    localparam int PROD_W     = 48;
    localparam int WS_W       = 32;
    localparam int THR_W      = 28;
    localparam int WCNT_W     = 8;
    localparam int PEAK_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int THR_SHIFT  = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK_GAP  = 2'd2;

    localparam logic [7:0]  WINDOW_RESET = 8'd20;
    localparam logic [15:0] SENS_RESET   = 16'd3482;
    localparam logic [9:0]  GAP_RESET    = 10'd10;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic               frame_end;
    } sample_t;

    typedef struct packed {
        logic [PEAK_W-1:0] peak_index;
        logic              peak_found;
        logic              peaks_dropped;
        logic              last_result;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_SQ_SUM,
        S_MAG_WAIT,
        S_MAG_ACC,
        S_DET_CHECK,
        S_MEAN_WAIT,
        S_MSQ_WAIT,
        S_VAR,
        S_DEV_WAIT,
        S_THR,
        S_INIT_ADDR,
        S_INIT_DATA,
        S_W_NEXT,
        S_W_ADD,
        S_W_SUB,
        S_W_MUL,
        S_W_DEC,
        S_FINAL
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_X,
        MUL_Y,
        MUL_Z,
        MUL_MAG,
        MUL_MEAN,
        MUL_SENS,
        MUL_WIN
    } mul_sel_t;

    typedef enum logic [1:0] {
        RD_INIT,
        RD_NEXT,
        RD_ADD,
        RD_SUB
    } rd_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     sq_load;
        logic     sq_acc;
        logic     sqrt_start;
        logic     sqrt_var;
        logic     mag_store;
        logic     sqsum_acc;
        logic     div_start;
        logic     div_sq;
        logic     mean_cap;
        logic     msq_cap;
        logic     thr_cap;
        rd_sel_t  rd_sel;
        logic     init_acc;
        logic     next_cap;
        logic     add_cap;
        logic     sub_cap;
        logic     dec;
        logic     final_emit;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic cnt_lt_max;
        logic n_lt3;
        logic div_done;
        logic div_busy;
        logic sqrt_done;
        logic sqrt_busy;
        logic init_last;
        logic walk_last;
        logic dec_block;
        logic out_free;
        logic pend_valid;
    } status_t;

endpackage

/* hw/rtl/apd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module apd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* hw/rtl/apd_sqrt.sv */
// Bit-serial floor square root, one root bit per cycle.
module apd_sqrt #(
    parameter int RW = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic            busy,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int REM_W = RW + 2;
    localparam int K_W   = $clog2(RW + 1);

    logic [2*RW-1:0]  rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [RW-1:0]    root_reg;
    logic [K_W-1:0]   k_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             take;

    assign rem_sh = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign trial  = (REM_W+2)'({root_reg, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= K_W'(RW - 1);
            end
            else if (busy_reg)
            begin
                if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
            rem_reg  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[RW-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

/* hw/rtl/apd_div.sv */
// Restoring divider, one quotient bit per cycle.
module apd_div #(
    parameter int DW = 58,
    parameter int VW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int K_W = $clog2(DW + 1);

    logic [DW-1:0] q_reg;
    logic [VW:0]   rem_reg;
    logic [VW-1:0] v_reg;
    logic [K_W-1:0] k_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   rem_sh;
    logic          take;

    assign rem_sh = {rem_reg[VW-1:0], q_reg[DW-1]};
    assign take   = rem_sh >= {1'b0, v_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= K_W'(DW - 1);
            end
            else if (busy_reg)
            begin
                if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            v_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DW-2:0], take};
            rem_reg <= take ? (rem_sh - {1'b0, v_reg}) : rem_sh;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* hw/rtl/apd_datapath.sv */
// Datapath: frame store, accumulators, shared multiplier, divider, root unit and output register.
module apd_datapath #(
    parameter int MAX_SAMPLES   = 1024,
    parameter int MAX_PEAKS_OUT = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  apd_pkg::sample_t                   sample,
    input  apd_pkg::cmd_t                      cmd,
    output apd_pkg::status_t                   st,
    input  logic                               cfg_we,
    input  logic [apd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               result_valid,
    input  logic                               result_ready,
    output apd_pkg::result_t                   result
);
    import apd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = MAG_W + CNT_W;
    localparam int DIV_W  = 2 * MAG_W + CNT_W;
    localparam int KEPT_W = $clog2(MAX_PEAKS_OUT + 1);
    localparam int EW     = ((CNT_W > PEAK_W) ? CNT_W : PEAK_W) + 2;

    // Configuration registers.
    logic [7:0]  window_reg;
    logic [15:0] sens_reg;
    logic [9:0]  gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            sens_reg   <= SENS_RESET;
            gap_reg    <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH: window_reg <= cfg_data[7:0];
                CFG_SENSITIVITY:   sens_reg   <= cfg_data;
                CFG_MIN_PEAK_GAP:  gap_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    function automatic logic [16:0] abs16(input logic [15:0] v);
        abs16 = v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
    endfunction

    sample_t             sample_reg;
    logic [SQ_W-1:0]     acc_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [MAG_W-1:0]    mul_a;
    logic [MAG_W-1:0]    mul_b;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [DIV_W-1:0]    sqsum_reg;
    logic [MAG_W-1:0]    mean_reg;
    logic [PROD_W-1:0]   msq_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [WS_W-1:0]     ws_reg;
    logic [WS_W-1:0]     ws_next;
    logic [MAG_W-1:0]    prev_reg;
    logic [MAG_W-1:0]    cur_reg;
    logic [MAG_W-1:0]    nxt_reg;
    logic [MAG_W-1:0]    addv_reg;
    logic [MAG_W-1:0]    subv_reg;
    logic [CNT_W-1:0]    i_reg;
    logic [CNT_W-1:0]    j_reg;
    logic [CNT_W-1:0]    last_reg;
    logic                have_reg;
    logic [KEPT_W-1:0]   kept_reg;
    logic [CNT_W-1:0]    pend_reg;
    logic                pend_valid_reg;
    logic                dropped_reg;
    logic                out_valid_reg;
    result_t             result_reg;

    logic [MAG_W-1:0]    root;
    logic                sqrt_busy;
    logic                sqrt_done;
    logic [2*MAG_W-1:0]  sqrt_in;
    logic [DIV_W-1:0]    div_q;
    logic                div_busy;
    logic                div_done;
    logic [MAG_W-1:0]    rdata;
    logic [IDX_W-1:0]    raddr;
    logic [PROD_W-1:0]   var_val;
    logic [SQ_W-1:0]     sq_total;

    logic [EW-1:0] h_ext, i_ext, n_ext, iph1, lo, hi, hi0, gap_diff;
    logic [WCNT_W-1:0] wcnt;
    logic [MAG_W-1:0] cur_minus_thr;
    logic cur_gt_thr, peak, gap_ok, keep, kept_full, out_free;

    // Shared multiplier with a registered product.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_X:    begin mul_a = MAG_W'(abs16(sample_reg.accel_x)); mul_b = mul_a; end
            MUL_Y:    begin mul_a = MAG_W'(abs16(sample_reg.accel_y)); mul_b = mul_a; end
            MUL_Z:    begin mul_a = MAG_W'(abs16(sample_reg.accel_z)); mul_b = mul_a; end
            MUL_MAG:  begin mul_a = root; mul_b = root; end
            MUL_MEAN: begin mul_a = mean_reg; mul_b = mean_reg; end
            MUL_SENS: begin mul_a = MAG_W'(sens_reg); mul_b = root; end
            MUL_WIN:  begin mul_a = cur_minus_thr; mul_b = MAG_W'(wcnt); end
            default:  ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign sq_total = acc_reg + prod_reg[SQ_W-1:0];
    assign var_val  = (msq_reg > prod_reg) ? (msq_reg - prod_reg) : '0;
    assign sqrt_in  = cmd.sqrt_var ? var_val : {sq_total, 16'b0};

    apd_sqrt #(.RW(MAG_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (sqrt_in),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (root)
    );

    apd_div #(.DW(DIV_W), .VW(CNT_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cmd.div_sq ? sqsum_reg : DIV_W'(sum_reg)),
        .divisor  (count_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Window bounds of the current index.
    assign h_ext = EW'(window_reg[7:1]);
    assign i_ext = EW'(i_reg);
    assign n_ext = EW'(count_reg);
    assign iph1  = i_ext + h_ext + EW'(1);
    assign lo    = (i_ext > h_ext) ? (i_ext - h_ext) : '0;
    assign hi    = (iph1 > n_ext) ? n_ext : iph1;
    assign wcnt  = WCNT_W'(hi - lo);
    assign hi0   = ((h_ext + EW'(2)) > n_ext) ? n_ext : (h_ext + EW'(2));

    always_comb
    begin
        case (cmd.rd_sel)
            RD_INIT: raddr = IDX_W'(j_reg);
            RD_NEXT: raddr = IDX_W'(i_ext + EW'(1));
            RD_ADD:  raddr = IDX_W'(iph1);
            default: raddr = IDX_W'(i_ext - h_ext);
        endcase
    end

    apd_ram #(.WIDTH(MAG_W), .DEPTH(MAX_SAMPLES)) u_store (
        .clk   (clk),
        .we    (cmd.mag_store),
        .waddr (IDX_W'(count_reg)),
        .wdata (root),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Peak decision. The average compare is done as ws < (cur - thr) * count.
    assign cur_gt_thr    = {{(THR_W-MAG_W){1'b0}}, cur_reg} > thr_reg;
    assign cur_minus_thr = MAG_W'({{(THR_W-MAG_W){1'b0}}, cur_reg} - thr_reg);
    assign peak      = cur_gt_thr && ({{(PROD_W-WS_W){1'b0}}, ws_reg} < prod_reg)
                       && (cur_reg > prev_reg) && (cur_reg > nxt_reg);
    assign gap_diff  = EW'(i_reg - last_reg);
    assign gap_ok    = !have_reg || (gap_diff >= EW'(gap_reg));
    assign keep      = peak && gap_ok;
    assign kept_full = kept_reg == KEPT_W'(MAX_PEAKS_OUT);
    assign out_free  = !out_valid_reg || result_ready;
    assign ws_next   = ws_reg + WS_W'(addv_reg) - WS_W'(subv_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
        end
        prod_reg <= prod_next;
        if (cmd.sq_load)
        begin
            acc_reg <= prod_reg[SQ_W-1:0];
        end
        else if (cmd.sq_acc)
        begin
            acc_reg <= sq_total;
        end
        if (cmd.mean_cap)
        begin
            mean_reg <= div_q[MAG_W-1:0];
        end
        if (cmd.msq_cap)
        begin
            msq_reg <= div_q[PROD_W-1:0];
        end
        if (cmd.thr_cap)
        begin
            thr_reg <= THR_W'(prod_reg >> THR_SHIFT);
            ws_reg  <= '0;
            j_reg   <= '0;
            i_reg   <= CNT_W'(1);
        end
        if (cmd.init_acc)
        begin
            // With a zero half-width the window of index 1 starts at index 1.
            if (j_reg != '0 || window_reg[7:1] != '0)
            begin
                ws_reg <= ws_reg + WS_W'(rdata);
            end
            j_reg  <= j_reg + 1'b1;
            if (j_reg == '0)
            begin
                prev_reg <= rdata;
            end
            if (j_reg == CNT_W'(1))
            begin
                cur_reg <= rdata;
            end
        end
        if (cmd.next_cap)
        begin
            nxt_reg <= rdata;
        end
        if (cmd.add_cap)
        begin
            addv_reg <= (iph1 < n_ext) ? rdata : '0;
        end
        if (cmd.sub_cap)
        begin
            subv_reg <= (i_ext >= h_ext) ? rdata : '0;
        end
        if (cmd.dec)
        begin
            ws_reg   <= ws_next;
            prev_reg <= cur_reg;
            cur_reg  <= nxt_reg;
            i_reg    <= i_reg + 1'b1;
            if (keep)
            begin
                last_reg <= i_reg;
                if (!kept_full)
                begin
                    pend_reg <= i_reg;
                end
            end
        end
        if (cmd.dec && keep && !kept_full && pend_valid_reg)
        begin
            result_reg <= '{peak_index: PEAK_W'(pend_reg), peak_found: 1'b1,
                            peaks_dropped: 1'b0, last_result: 1'b0};
        end
        else if (cmd.final_emit)
        begin
            result_reg <= '{peak_index: pend_valid_reg ? PEAK_W'(pend_reg) : '0,
                            peak_found: pend_valid_reg,
                            peaks_dropped: dropped_reg, last_result: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            sum_reg        <= '0;
            sqsum_reg      <= '0;
            have_reg       <= 1'b0;
            kept_reg       <= '0;
            pend_valid_reg <= 1'b0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.final_emit || (cmd.dec && keep && !kept_full && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.mag_store)
            begin
                sum_reg <= sum_reg + SUM_W'(root);
            end
            if (cmd.sqsum_acc)
            begin
                sqsum_reg <= sqsum_reg + DIV_W'(prod_reg);
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.dec && keep)
            begin
                have_reg <= 1'b1;
                if (kept_full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    kept_reg       <= kept_reg + 1'b1;
                    pend_valid_reg <= 1'b1;
                end
            end
            if (cmd.final_emit)
            begin
                count_reg      <= '0;
                sum_reg        <= '0;
                sqsum_reg      <= '0;
                have_reg       <= 1'b0;
                kept_reg       <= '0;
                pend_valid_reg <= 1'b0;
                dropped_reg    <= 1'b0;
            end
        end
    end

    assign st.frame_end  = sample_reg.frame_end;
    assign st.cnt_lt_max = count_reg < CNT_W'(MAX_SAMPLES);
    assign st.n_lt3      = count_reg < CNT_W'(3);
    assign st.div_done   = div_done;
    assign st.div_busy   = div_busy;
    assign st.sqrt_done  = sqrt_done;
    assign st.sqrt_busy  = sqrt_busy;
    assign st.init_last  = (EW'(j_reg) + EW'(1)) == hi0;
    assign st.walk_last  = (i_ext + EW'(2)) >= n_ext;
    assign st.dec_block  = keep && !kept_full && pend_valid_reg && !out_free;
    assign st.out_free   = out_free;
    assign st.pend_valid = pend_valid_reg;

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

/* hw/rtl/apd_ctrl.sv */
// Controller state machine: sequences sample loading, statistics and the detection walk.
module apd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  apd_pkg::status_t st,
    output apd_pkg::cmd_t    cmd
);
    import apd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (sample_valid) state_next = S_SQ_X;
            S_SQ_X:
            begin
                if (st.cnt_lt_max)     state_next = S_SQ_Y;
                else if (st.frame_end) state_next = S_DET_CHECK;
                else                   state_next = S_IDLE;
            end
            S_SQ_Y:      state_next = S_SQ_Z;
            S_SQ_Z:      state_next = S_SQ_SUM;
            S_SQ_SUM:    state_next = S_MAG_WAIT;
            S_MAG_WAIT:  if (st.sqrt_done) state_next = S_MAG_ACC;
            S_MAG_ACC:   state_next = st.frame_end ? S_DET_CHECK : S_IDLE;
            S_DET_CHECK: state_next = st.n_lt3 ? S_FINAL : S_MEAN_WAIT;
            S_MEAN_WAIT: if (st.div_done) state_next = S_MSQ_WAIT;
            S_MSQ_WAIT:  if (st.div_done) state_next = S_VAR;
            S_VAR:       state_next = S_DEV_WAIT;
            S_DEV_WAIT:  if (st.sqrt_done) state_next = S_THR;
            S_THR:       state_next = S_INIT_ADDR;
            S_INIT_ADDR: state_next = S_INIT_DATA;
            S_INIT_DATA: state_next = st.init_last ? S_W_NEXT : S_INIT_ADDR;
            S_W_NEXT:    state_next = S_W_ADD;
            S_W_ADD:     state_next = S_W_SUB;
            S_W_SUB:     state_next = S_W_MUL;
            S_W_MUL:     state_next = S_W_DEC;
            S_W_DEC:
            begin
                if (!st.dec_block)
                begin
                    state_next = st.walk_last ? S_FINAL : S_W_NEXT;
                end
            end
            S_FINAL:     if (st.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MUL_NONE;
        cmd.rd_sel   = RD_INIT;
        sample_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                cmd.load     = sample_valid;
            end
            S_SQ_X:      cmd.mul_sel = MUL_X;
            S_SQ_Y:
            begin
                cmd.mul_sel = MUL_Y;
                cmd.sq_load = 1'b1;
            end
            S_SQ_Z:
            begin
                cmd.mul_sel = MUL_Z;
                cmd.sq_acc  = 1'b1;
            end
            S_SQ_SUM:    cmd.sqrt_start = 1'b1;
            S_MAG_WAIT:
            begin
                cmd.mul_sel   = MUL_MAG;
                cmd.mag_store = st.sqrt_done;
            end
            S_MAG_ACC:   cmd.sqsum_acc = 1'b1;
            S_DET_CHECK: cmd.div_start = !st.n_lt3;
            S_MEAN_WAIT:
            begin
                cmd.mean_cap  = st.div_done;
                cmd.div_start = st.div_done;
                cmd.div_sq    = 1'b1;
            end
            S_MSQ_WAIT:
            begin
                cmd.msq_cap = st.div_done;
                cmd.mul_sel = MUL_MEAN;
            end
            S_VAR:
            begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_var   = 1'b1;
            end
            S_DEV_WAIT:  cmd.mul_sel = MUL_SENS;
            S_THR:       cmd.thr_cap = 1'b1;
            S_INIT_ADDR: cmd.rd_sel = RD_INIT;
            S_INIT_DATA: cmd.init_acc = 1'b1;
            S_W_NEXT:    cmd.rd_sel = RD_NEXT;
            S_W_ADD:
            begin
                cmd.next_cap = 1'b1;
                cmd.rd_sel   = RD_ADD;
            end
            S_W_SUB:
            begin
                cmd.add_cap = 1'b1;
                cmd.rd_sel  = RD_SUB;
            end
            S_W_MUL:
            begin
                cmd.sub_cap = 1'b1;
                cmd.mul_sel = MUL_WIN;
            end
            S_W_DEC:
            begin
                cmd.mul_sel = MUL_WIN;
                cmd.dec     = !st.dec_block;
            end
            S_FINAL:     cmd.final_emit = st.out_free;
            default: ;
        endcase
    end

endmodule

/* hw/rtl/accel_peak_detector.sv */
// Top level of the accelerometer peak detector: controller, datapath and checks.
//
// Samples of a frame are taken one transaction at a time. Each sample is squared
// axis by axis on the shared multiplier, and its Q.8 magnitude is formed by the
// bit-serial square root (24 root bits at one bit a cycle).
// The transaction that carries frame_end starts detection: two divisions by the
// sample count at one quotient bit a cycle (59 quotient bits each with the default
// frame depth), one more square root for the standard deviation, a window preload
// of min(n, window_length / 2 + 2) magnitudes, and then a walk over indices 1 to
// n-2, paced by the single read port of the magnitude store.
// Kept peak indices come out as result transactions in order; the last one of a
// frame carries last_result, and peaks_dropped when more than MAX_PEAKS_OUT peaks
// were found. A frame with no kept peak, or fewer than three samples, gives one
// report with peak_found low. Samples beyond MAX_SAMPLES are ignored. No new
// sample is taken while a frame is being processed. Configuration writes land in
// their registers directly and are meant to be made while the block is idle.
module accel_peak_detector #(
    parameter int MAX_SAMPLES   = 1024,
    parameter int MAX_PEAKS_OUT = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  apd_pkg::sample_t               sample,
    output logic                           result_valid,
    input  logic                           result_ready,
    output apd_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [apd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import apd_pkg::*;

    cmd_t    cmd;
    status_t st;

    apd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .st           (st),
        .cmd          (cmd)
    );

    apd_datapath #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .MAX_PEAKS_OUT (MAX_PEAKS_OUT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .st           (st),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // While a new sample can be taken, neither iterative unit may still be running.
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> !(st.div_busy || st.sqrt_busy))
        else $error("iterative unit busy while accepting samples");

    // A held peak must have been flushed by the end of the frame.
    a_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> !st.pend_valid)
        else $error("pending peak left over after frame");

    // A peak decision never commits while it would overwrite a waiting result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.dec && st.dec_block))
        else $error("peak decision committed with output register full");

    // The final report is only issued into a free output register.
    a_final_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_emit |-> st.out_free)
        else $error("final report issued with output register full");

endmodule
